// File: sv/vmu_pkg.sv
// shared types and constants of the vector math unit
package vmu_pkg;

    localparam int OUT_BITS = 32;

    typedef enum logic [2:0] {
        FN_ADD   = 3'd0,
        FN_SUB   = 3'd1,
        FN_SCALE = 3'd2,
        FN_DOT   = 3'd3,
        FN_CROSS = 3'd4,
        FN_MAG   = 3'd5,
        FN_UNIT  = 3'd6,
        FN_EQUAL = 3'd7
    } t_func;

    typedef struct packed {
        logic [OUT_BITS-1:0] res_x;
        logic [OUT_BITS-1:0] res_y;
        logic [OUT_BITS-1:0] res_z;
        logic [OUT_BITS-1:0] res_scalar;
        logic                is_equal;
        logic                zero_length;
        logic                saturated;
    } t_result;

endpackage

// File: sv/vmu_front.sv
// front pipeline: operand capture, products, sums, rounding and saturation
module vmu_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [2:0]                          i_func,
    input  logic signed [vmu_pkg::OUT_BITS-1:0] i_ax,
    input  logic signed [vmu_pkg::OUT_BITS-1:0] i_ay,
    input  logic signed [vmu_pkg::OUT_BITS-1:0] i_az,
    input  logic signed [vmu_pkg::OUT_BITS-1:0] i_bx,
    input  logic signed [vmu_pkg::OUT_BITS-1:0] i_by,
    input  logic signed [vmu_pkg::OUT_BITS-1:0] i_bz,
    input  logic signed [vmu_pkg::OUT_BITS-1:0] i_factor,
    output logic                                o_valid,
    output vmu_pkg::t_func                      o_func,
    output logic [vmu_pkg::OUT_BITS-1:0]        o_res_x,
    output logic [vmu_pkg::OUT_BITS-1:0]        o_res_y,
    output logic [vmu_pkg::OUT_BITS-1:0]        o_res_z,
    output logic [vmu_pkg::OUT_BITS-1:0]        o_res_scalar,
    output logic                                o_is_equal,
    output logic                                o_saturated,
    output logic [2:0]                          o_neg,
    output logic [3*W-1:0]                      o_amag,
    output logic [2*W-1:0]                      o_sq
);

    localparam int OB = vmu_pkg::OUT_BITS;
    localparam logic signed [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [2*W+2:0] MAX_L = {{(W+4){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [2*W+2:0] MIN_L = ~MAX_L;
    localparam logic signed [2*W+2:0] HALF_R = (2*W+3)'(1) << (F-1);

    // stage 0: operand capture
    logic                  r_s0_valid;
    vmu_pkg::t_func        r_s0_func;
    logic signed [W-1:0]   r_s0_a [3];
    logic signed [W-1:0]   r_s0_b [3];
    logic signed [W-1:0]   r_s0_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (i_en) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_func <= vmu_pkg::t_func'(i_func);
            r_s0_a[0] <= W'($unsigned(i_ax));
            r_s0_a[1] <= W'($unsigned(i_ay));
            r_s0_a[2] <= W'($unsigned(i_az));
            r_s0_b[0] <= W'($unsigned(i_bx));
            r_s0_b[1] <= W'($unsigned(i_by));
            r_s0_b[2] <= W'($unsigned(i_bz));
            r_s0_f    <= W'($unsigned(i_factor));
        end
    end

    // stage 1: shared multipliers, add and sub
    logic signed [W-1:0]   op_l [6];
    logic signed [W-1:0]   op_r [6];
    logic signed [2*W-1:0] prod [6];
    logic signed [W:0]     as_wide [3];
    logic signed [W-1:0]   as_val [3];
    logic                  as_sat;
    logic                  eq;
    logic [2:0]            neg;
    logic [W-1:0]          amag [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            op_l[k]   = r_s0_a[k];
            op_r[k]   = r_s0_b[k];
            op_l[k+3] = '0;
            op_r[k+3] = '0;
        end
        unique case (r_s0_func) inside
            vmu_pkg::FN_SCALE: begin
                for (int k = 0; k < 3; k++) begin
                    op_r[k] = r_s0_f;
                end
            end
            vmu_pkg::FN_CROSS: begin
                op_l[0] = r_s0_a[1]; op_r[0] = r_s0_b[2];
                op_l[1] = r_s0_a[2]; op_r[1] = r_s0_b[0];
                op_l[2] = r_s0_a[0]; op_r[2] = r_s0_b[1];
                op_l[3] = r_s0_a[2]; op_r[3] = r_s0_b[1];
                op_l[4] = r_s0_a[0]; op_r[4] = r_s0_b[2];
                op_l[5] = r_s0_a[1]; op_r[5] = r_s0_b[0];
            end
            vmu_pkg::FN_MAG, vmu_pkg::FN_UNIT: begin
                for (int k = 0; k < 3; k++) begin
                    op_r[k] = r_s0_a[k];
                end
            end
            default: ;
        endcase
        for (int k = 0; k < 6; k++) begin
            prod[k] = op_l[k] * op_r[k];
        end
        as_sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (r_s0_func == vmu_pkg::FN_SUB) begin
                as_wide[k] = {r_s0_a[k][W-1], r_s0_a[k]} - {r_s0_b[k][W-1], r_s0_b[k]};
            end else begin
                as_wide[k] = {r_s0_a[k][W-1], r_s0_a[k]} + {r_s0_b[k][W-1], r_s0_b[k]};
            end
            if (as_wide[k][W] != as_wide[k][W-1]) begin
                as_sat    = 1'b1;
                as_val[k] = as_wide[k][W] ? MIN_W : MAX_W;
            end else begin
                as_val[k] = as_wide[k][W-1:0];
            end
            neg[k]  = r_s0_a[k][W-1];
            amag[k] = neg[k] ? W'(-r_s0_a[k]) : r_s0_a[k];
        end
        eq = (r_s0_a[0] == r_s0_b[0]) && (r_s0_a[1] == r_s0_b[1]) && (r_s0_a[2] == r_s0_b[2]);
    end

    logic                  r_s1_valid;
    vmu_pkg::t_func        r_s1_func;
    logic signed [2*W-1:0] r_s1_p [6];
    logic signed [W-1:0]   r_s1_as [3];
    logic                  r_s1_as_sat;
    logic                  r_s1_eq;
    logic [2:0]            r_s1_neg;
    logic [W-1:0]          r_s1_amag [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_func   <= r_s0_func;
            r_s1_p      <= prod;
            r_s1_as     <= as_val;
            r_s1_as_sat <= as_sat;
            r_s1_eq     <= eq;
            r_s1_neg    <= neg;
            r_s1_amag   <= amag;
        end
    end

    // stage 2: sums of products
    logic signed [2*W+1:0] t [3];
    logic signed [2*W+1:0] ts;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_s1_func == vmu_pkg::FN_CROSS) begin
                t[k] = (2*W+2)'(r_s1_p[k]) - (2*W+2)'(r_s1_p[k+3]);
            end else begin
                t[k] = (2*W+2)'(r_s1_p[k]);
            end
        end
        ts = (2*W+2)'(r_s1_p[0]) + (2*W+2)'(r_s1_p[1]) + (2*W+2)'(r_s1_p[2]);
    end

    logic                  r_s2_valid;
    vmu_pkg::t_func        r_s2_func;
    logic signed [2*W+1:0] r_s2_t [3];
    logic signed [2*W+1:0] r_s2_ts;
    logic [2*W-1:0]        r_s2_sq;
    logic signed [W-1:0]   r_s2_as [3];
    logic                  r_s2_as_sat;
    logic                  r_s2_eq;
    logic [2:0]            r_s2_neg;
    logic [W-1:0]          r_s2_amag [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_func   <= r_s1_func;
            r_s2_t      <= t;
            r_s2_ts     <= ts;
            r_s2_sq     <= ts[2*W-1:0];
            r_s2_as     <= r_s1_as;
            r_s2_as_sat <= r_s1_as_sat;
            r_s2_eq     <= r_s1_eq;
            r_s2_neg    <= r_s1_neg;
            r_s2_amag   <= r_s1_amag;
        end
    end

    // stage 3: round half up, saturate, pick by function
    function automatic logic [W:0] round_sat(input logic signed [2*W+1:0] x);
        logic signed [2*W+2:0] y;
        y = ((2*W+3)'(x) + HALF_R) >>> F;
        if (y > MAX_L) begin
            return {1'b1, MAX_W};
        end else if (y < MIN_L) begin
            return {1'b1, MIN_W};
        end
        return {1'b0, y[W-1:0]};
    endfunction

    logic [W:0]          rs_v [3];
    logic [W:0]          rs_s;
    logic signed [W-1:0] v [3];
    logic signed [W-1:0] s;
    logic                sat;
    logic                eq_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rs_v[k] = round_sat(r_s2_t[k]);
            v[k]    = '0;
        end
        rs_s   = round_sat(r_s2_ts);
        s      = '0;
        sat    = 1'b0;
        eq_out = 1'b0;
        unique case (r_s2_func) inside
            vmu_pkg::FN_ADD, vmu_pkg::FN_SUB: begin
                v   = r_s2_as;
                sat = r_s2_as_sat;
            end
            vmu_pkg::FN_SCALE, vmu_pkg::FN_CROSS: begin
                for (int k = 0; k < 3; k++) begin
                    v[k] = rs_v[k][W-1:0];
                end
                sat = rs_v[0][W] | rs_v[1][W] | rs_v[2][W];
            end
            vmu_pkg::FN_DOT: begin
                s   = rs_s[W-1:0];
                sat = rs_s[W];
            end
            vmu_pkg::FN_EQUAL: begin
                eq_out = r_s2_eq;
            end
            default: ;
        endcase
    end

    logic r_s3_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_func       <= r_s2_func;
            o_res_x      <= OB'(v[0]);
            o_res_y      <= OB'(v[1]);
            o_res_z      <= OB'(v[2]);
            o_res_scalar <= OB'(s);
            o_is_equal   <= eq_out;
            o_saturated  <= sat;
            o_neg        <= r_s2_neg;
            o_sq         <= r_s2_sq;
            for (int k = 0; k < 3; k++) begin
                o_amag[k*W +: W] <= r_s2_amag[k];
            end
        end
    end

    assign o_valid = r_s3_valid;

endmodule

// File: sv/vmu_sqrt_cell.sv
// one square root cell: decides one root bit and passes the word on
module vmu_sqrt_cell #(
    parameter int W    = 32,
    parameter int STEP = 0,
    parameter int CW   = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [2*W-1:0] i_rem,
    input  logic [W-1:0]   i_root,
    input  logic [CW-1:0]  i_carry,
    output logic           o_valid,
    output logic [2*W-1:0] o_rem,
    output logic [W-1:0]   o_root,
    output logic [CW-1:0]  o_carry
);

    logic           r_valid;
    logic [2*W-1:0] r_rem;
    logic [W-1:0]   r_root;
    logic [CW-1:0]  r_carry;
    logic [2*W-1:0] trial;
    logic           take;

    assign trial = ((2*W)'(i_root) << (STEP+1)) | ((2*W)'(1) << (2*STEP));
    assign take  = i_rem >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= take ? i_rem - trial : i_rem;
            r_root  <= take ? (i_root | (W'(1) << STEP)) : i_root;
            r_carry <= i_carry;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_carry = r_carry;

endmodule

// File: sv/vmu_div_cell.sv
// one divider cell: decides one quotient bit for each of three lanes
module vmu_div_cell #(
    parameter int W    = 32,
    parameter int F    = 16,
    parameter int STEP = 0,
    parameter int CW   = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [W-1:0]   i_m,
    input  logic [W+F-1:0] i_rem [3],
    input  logic [F:0]     i_q [3],
    input  logic [CW-1:0]  i_carry,
    output logic           o_valid,
    output logic [W-1:0]   o_m,
    output logic [W+F-1:0] o_rem [3],
    output logic [F:0]     o_q [3],
    output logic [CW-1:0]  o_carry
);

    logic           r_valid;
    logic [W-1:0]   r_m;
    logic [W+F-1:0] r_rem [3];
    logic [F:0]     r_q [3];
    logic [CW-1:0]  r_carry;
    logic [W+F-1:0] trial;

    assign trial = (W+F)'(i_m) << STEP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m     <= i_m;
            r_carry <= i_carry;
            for (int k = 0; k < 3; k++) begin
                if (i_rem[k] >= trial) begin
                    r_rem[k] <= i_rem[k] - trial;
                    r_q[k]   <= i_q[k] | ((F+1)'(1) << STEP);
                end else begin
                    r_rem[k] <= i_rem[k];
                    r_q[k]   <= i_q[k];
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_m     = r_m;
    assign o_rem   = r_rem;
    assign o_q     = r_q;
    assign o_carry = r_carry;

endmodule

// File: sv/vector3_math_unit_top.sv
// A word accepted at the input passes four front stages, one square root cell per root bit,
// two stages for magnitude rounding and numerators, one divider cell per quotient bit and
// the output register.
// Throughput: one word per cycle while o_stall is low; every cell then hands its word to the next.
// The output register plus a one-word skid register decouple the two stall signals.
// Reset is synchronous and active low and empties every stage; no payload is cleared.
module vector3_math_unit_top #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [2:0]                          i_func,
    input  logic signed [vmu_pkg::OUT_BITS-1:0] i_ax,
    input  logic signed [vmu_pkg::OUT_BITS-1:0] i_ay,
    input  logic signed [vmu_pkg::OUT_BITS-1:0] i_az,
    input  logic signed [vmu_pkg::OUT_BITS-1:0] i_bx,
    input  logic signed [vmu_pkg::OUT_BITS-1:0] i_by,
    input  logic signed [vmu_pkg::OUT_BITS-1:0] i_bz,
    input  logic signed [vmu_pkg::OUT_BITS-1:0] i_factor,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [vmu_pkg::OUT_BITS-1:0] o_res_x,
    output logic signed [vmu_pkg::OUT_BITS-1:0] o_res_y,
    output logic signed [vmu_pkg::OUT_BITS-1:0] o_res_z,
    output logic signed [vmu_pkg::OUT_BITS-1:0] o_res_scalar,
    output logic                                o_is_equal,
    output logic                                o_zero_length,
    output logic                                o_saturated
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int OB = vmu_pkg::OUT_BITS;
    localparam int CW = 3 + 4*OB + 2 + 3 + 3*W;
    localparam int P_NEG = 3*W;
    localparam int P_SAT = P_NEG + 3;
    localparam int P_EQ  = P_SAT + 1;
    localparam int P_RS  = P_EQ + 1;
    localparam int P_RZ  = P_RS + OB;
    localparam int P_RY  = P_RZ + OB;
    localparam int P_RX  = P_RY + OB;
    localparam int P_FN  = P_RX + OB;
    localparam logic signed [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic [W+F:0] QLIM_P = {{(F+2){1'b0}}, {(W-1){1'b1}}};
    localparam logic [W+F:0] QLIM_N = {{(F+1){1'b0}}, 1'b1, {(W-1){1'b0}}};

    logic en;
    logic r_sk_valid;

    assign en      = ~r_sk_valid;
    assign o_stall = r_sk_valid;

    // front stages
    logic                  f_valid;
    vmu_pkg::t_func        f_func;
    logic [OB-1:0]         f_rx, f_ry, f_rz, f_rs;
    logic                  f_eq, f_sat;
    logic [2:0]            f_neg;
    logic [3*W-1:0]        f_amag;
    logic [2*W-1:0]        f_sq;

    vmu_front #(.W(W), .F(F)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .i_func       (i_func),
        .i_ax         (i_ax),
        .i_ay         (i_ay),
        .i_az         (i_az),
        .i_bx         (i_bx),
        .i_by         (i_by),
        .i_bz         (i_bz),
        .i_factor     (i_factor),
        .o_valid      (f_valid),
        .o_func       (f_func),
        .o_res_x      (f_rx),
        .o_res_y      (f_ry),
        .o_res_z      (f_rz),
        .o_res_scalar (f_rs),
        .o_is_equal   (f_eq),
        .o_saturated  (f_sat),
        .o_neg        (f_neg),
        .o_amag       (f_amag),
        .o_sq         (f_sq)
    );

    // square root chain
    logic           s_valid [W+1];
    logic [2*W-1:0] s_rem   [W+1];
    logic [W-1:0]   s_root  [W+1];
    logic [CW-1:0]  s_carry [W+1];

    assign s_valid[0] = f_valid;
    assign s_rem[0]   = f_sq;
    assign s_root[0]  = '0;
    assign s_carry[0] = {f_func, f_rx, f_ry, f_rz, f_rs, f_eq, f_sat, f_neg, f_amag};

    for (genvar g = 0; g < W; g++) begin : g_sqrt
        vmu_sqrt_cell #(.W(W), .STEP(W-1-g), .CW(CW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_valid[g]),
            .i_rem   (s_rem[g]),
            .i_root  (s_root[g]),
            .i_carry (s_carry[g]),
            .o_valid (s_valid[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_root  (s_root[g+1]),
            .o_carry (s_carry[g+1])
        );
    end

    // magnitude rounding
    logic          r_m_valid;
    logic [W-1:0]  r_m;
    logic [CW-1:0] r_m_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= s_valid[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m       <= s_root[W] + W'(s_rem[W] > (2*W)'(s_root[W]));
            r_m_carry <= s_carry[W];
        end
    end

    // numerators with half divisor added
    logic           r_n_valid;
    logic [W-1:0]   r_n_m;
    logic [W+F-1:0] r_n_rem [3];
    logic [CW-1:0]  r_n_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (en) begin
            r_n_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_m     <= r_m;
            r_n_carry <= r_m_carry;
            for (int k = 0; k < 3; k++) begin
                r_n_rem[k] <= ((W+F)'(r_m_carry[k*W +: W]) << F) + (W+F)'(r_m >> 1);
            end
        end
    end

    // divider chain
    logic           d_valid [F+2];
    logic [W-1:0]   d_m     [F+2];
    logic [W+F-1:0] d_rem   [F+2][3];
    logic [F:0]     d_q     [F+2][3];
    logic [CW-1:0]  d_carry [F+2];

    assign d_valid[0] = r_n_valid;
    assign d_m[0]     = r_n_m;
    assign d_rem[0]   = r_n_rem;
    assign d_carry[0] = r_n_carry;
    assign d_q[0][0]  = '0;
    assign d_q[0][1]  = '0;
    assign d_q[0][2]  = '0;

    for (genvar g = 0; g <= F; g++) begin : g_div
        vmu_div_cell #(.W(W), .F(F), .STEP(F-g), .CW(CW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d_valid[g]),
            .i_m     (d_m[g]),
            .i_rem   (d_rem[g]),
            .i_q     (d_q[g]),
            .i_carry (d_carry[g]),
            .o_valid (d_valid[g+1]),
            .o_m     (d_m[g+1]),
            .o_rem   (d_rem[g+1]),
            .o_q     (d_q[g+1]),
            .o_carry (d_carry[g+1])
        );
    end

    // result assembly
    vmu_pkg::t_result    fin;
    logic                fin_valid;
    logic [CW-1:0]       c;
    logic [W-1:0]        m;
    logic [W+F:0]        qw;
    logic signed [W-1:0] uv [3];
    logic                usat;

    assign fin_valid = d_valid[F+1];
    assign c         = d_carry[F+1];
    assign m         = d_m[F+1];

    always_comb begin
        usat = 1'b0;
        qw   = '0;
        for (int k = 0; k < 3; k++) begin
            qw = (W+F+1)'(d_q[F+1][k]);
            if (!c[P_NEG+k]) begin
                if (qw > QLIM_P) begin
                    uv[k] = MAX_W;
                    usat  = 1'b1;
                end else begin
                    uv[k] = W'(qw);
                end
            end else begin
                if (qw > QLIM_N) begin
                    uv[k] = MIN_W;
                    usat  = 1'b1;
                end else begin
                    uv[k] = W'(-qw);
                end
            end
        end
        fin = '0;
        unique case (vmu_pkg::t_func'(c[P_FN +: 3])) inside
            vmu_pkg::FN_MAG: begin
                if (m[W-1]) begin
                    fin.res_scalar = OB'(MAX_W);
                    fin.saturated  = 1'b1;
                end else begin
                    fin.res_scalar = OB'(signed'(m));
                end
            end
            vmu_pkg::FN_UNIT: begin
                if (m == '0) begin
                    fin.zero_length = 1'b1;
                end else begin
                    fin.res_x     = OB'(uv[0]);
                    fin.res_y     = OB'(uv[1]);
                    fin.res_z     = OB'(uv[2]);
                    fin.saturated = usat;
                end
            end
            default: begin
                fin.res_x      = c[P_RX +: OB];
                fin.res_y      = c[P_RY +: OB];
                fin.res_z      = c[P_RZ +: OB];
                fin.res_scalar = c[P_RS +: OB];
                fin.is_equal   = c[P_EQ];
                fin.saturated  = c[P_SAT];
            end
        endcase
    end

    // output register and skid word
    logic              r_out_valid;
    vmu_pkg::t_result  r_out;
    vmu_pkg::t_result  r_sk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_sk_valid) begin
            if (!i_stall) begin
                r_sk_valid <= 1'b0;
            end
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= fin_valid;
        end else if (fin_valid) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_valid) begin
            if (!i_stall) begin
                r_out <= r_sk;
            end
        end else if (!r_out_valid || !i_stall) begin
            r_out <= fin;
        end else begin
            r_sk <= fin;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_res_x       = r_out.res_x;
    assign o_res_y       = r_out.res_y;
    assign o_res_z       = r_out.res_z;
    assign o_res_scalar  = r_out.res_scalar;
    assign o_is_equal    = r_out.is_equal;
    assign o_zero_length = r_out.zero_length;
    assign o_saturated   = r_out.saturated;

`ifndef NO_ASSERTIONS
    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid word held with empty output register");
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_valid) |-> $past(r_out_valid && i_stall && fin_valid))
        else $error("skid filled without a stalled output");
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_length) |-> (o_res_x == 0 && o_res_y == 0 && o_res_z == 0
            && o_res_scalar == 0 && !o_saturated && !o_is_equal))
        else $error("zero length word carries values");
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_valid && !i_stall) |=> (o_valid && !r_sk_valid))
        else $error("skid word not moved to output");
`endif

endmodule
